/* rtl/afr_pkg.sv */
// shared constants and types of the api frame receiver
package afr_pkg;

    localparam int unsigned POS_W      = 17;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned ADDR_W     = 64;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [BYTE_W-1:0] START_MARK   = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_MARK  = 8'h7D;
    localparam logic [BYTE_W-1:0] ESCAPE_FLIP  = 8'h20;
    localparam logic [BYTE_W-1:0] SUM_BASE     = 8'hFF;
    localparam logic [LEN_W-1:0]  HEADER_BYTES = 16'd12;

    localparam logic [POS_W-1:0] POS_HUNT       = 17'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI     = 17'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO     = 17'd2;
    localparam logic [POS_W-1:0] POS_TYPE       = 17'd3;
    localparam logic [POS_W-1:0] POS_STATUS     = 17'd8;
    localparam logic [POS_W-1:0] POS_STATUS_END = 17'd10;
    localparam logic [POS_W-1:0] POS_ADDR_END   = 17'd11;
    localparam logic [POS_W-1:0] POS_PAYLOAD    = 17'd15;
    localparam logic [POS_W-1:0] POS_TAIL       = 17'd2;

    localparam logic [BYTE_W-1:0] RECEIVE_TYPE_RESET = 8'h90;
    localparam logic [BYTE_W-1:0] STATUS_TYPE_RESET  = 8'h8B;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECEIVE_TYPE = 1'b0,
        REG_STATUS_TYPE  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_REPORT  = 1'b1
    } result_kind_t;

    typedef struct packed {
        result_kind_t        result_kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [LEN_W-1:0]    payload_index;
        logic [BYTE_W-1:0]   frame_kind_code;
        logic [ADDR_W-1:0]   sender_address;
        logic [BYTE_W-1:0]   delivery_status;
        logic [LEN_W-1:0]    payload_length;
        logic                checksum_ok;
    } afr_result_t;

endpackage

/* rtl/afr_in_if.sv */
// input channel carrying one received serial byte per item
interface afr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/afr_out_if.sv */
// output channel carrying payload bytes and end of frame reports
interface afr_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_kind_code;
    logic [63:0] sender_address;
    logic [7:0]  delivery_status;
    logic [15:0] payload_length;
    logic        checksum_ok;

    modport source (
        output valid, output result_kind, output payload_byte, output payload_index,
        output frame_kind_code, output sender_address, output delivery_status,
        output payload_length, output checksum_ok, input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input payload_index,
        input frame_kind_code, input sender_address, input delivery_status,
        input payload_length, input checksum_ok, output ready
    );
endinterface

/* rtl/api_frame_receiver_core.sv */
// top level: escaped api frame parser with registered result output
// Takes one serial byte per cycle unless the output stalls and parses escaped
// API frames: hunts for the 0x7E start byte, undoes 0x7D escaping, and reads
// length, type and body. Each payload byte of a receive frame comes out as an
// item with its index; each frame ends with one report item (type, last
// delivery status, last sender address, payload length, checksum match). Every
// byte is handled in the cycle it is accepted; its result sits in a single
// output register: one byte per clock whenever that register is empty or being
// drained, the rate set by downstream ready alone. The user writes type codes
// through the cfg port while the block is idle; the block does not enforce it.
module api_frame_receiver_core (
    input  logic                            clk,
    input  logic                            rst_n,
    afr_in_if.sink                          rx_in,
    afr_out_if.source                       res_out,
    input  logic                            cfg_we,
    input  logic [afr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [afr_pkg::BYTE_W-1:0]      cfg_data
);
    import afr_pkg::*;

    logic [BYTE_W-1:0] receive_code_reg;
    logic [BYTE_W-1:0] status_code_reg;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] kind_reg, kind_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              esc_reg, esc_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0] status_reg, status_next;

    logic              out_valid_reg;
    afr_result_t       out_item_reg;

    logic              accept;
    logic              emit;
    afr_result_t       item;
    logic [BYTE_W-1:0] b;
    logic [POS_W-1:0]  last_data;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  pay_off;
    logic              is_status;
    logic              is_receive;

    assign rx_in.ready = !out_valid_reg || res_out.ready;
    assign accept      = rx_in.valid && rx_in.ready;
    assign last_data   = {1'b0, len_reg} + POS_TAIL;
    assign pos_inc     = pos_reg + POS_W'(1);
    assign pay_off     = pos_reg - POS_PAYLOAD;
    assign is_status   = (kind_reg == status_code_reg);
    assign is_receive  = (kind_reg == receive_code_reg);

    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        kind_next   = kind_reg;
        sum_next    = sum_reg;
        esc_next    = esc_reg;
        addr_next   = addr_reg;
        status_next = status_reg;
        emit        = 1'b0;
        item        = '0;
        b           = rx_in.rx_byte;

        if (esc_reg || pos_reg == POS_HUNT || rx_in.rx_byte != ESCAPE_MARK)
        begin
            if (esc_reg)
            begin
                b        = rx_in.rx_byte ^ ESCAPE_FLIP;
                esc_next = 1'b0;
            end
            if (pos_reg == POS_HUNT)
            begin
                if (b == START_MARK)
                begin
                    pos_next = POS_LEN_HI;
                    sum_next = '0;
                end
            end
            else if (pos_reg == POS_LEN_HI)
            begin
                len_next = {{(LEN_W-BYTE_W){1'b0}}, b};
                pos_next = POS_LEN_LO;
            end
            else if (pos_reg == POS_LEN_LO)
            begin
                len_next = {len_reg[BYTE_W-1:0], b};
                pos_next = POS_TYPE;
            end
            else if (pos_reg == POS_TYPE)
            begin
                kind_next = b;
                sum_next  = sum_reg + b;
                pos_next  = pos_inc;
            end
            else if ((is_status && pos_reg >= POS_STATUS_END)
                     || (!is_status && pos_reg > last_data
                         && (!is_receive || pos_reg >= POS_PAYLOAD)))
            begin
                emit                 = 1'b1;
                item.result_kind     = KIND_REPORT;
                item.frame_kind_code = kind_reg;
                item.sender_address  = addr_reg;
                item.delivery_status = status_reg;
                item.payload_length  = (len_reg >= HEADER_BYTES) ? len_reg - HEADER_BYTES
                                                                 : '0;
                item.checksum_ok     = ((SUM_BASE - sum_reg) == b);
                pos_next             = POS_HUNT;
                sum_next             = '0;
            end
            else
            begin
                sum_next = sum_reg + b;
                pos_next = pos_inc;
                if (is_status)
                begin
                    if (pos_reg == POS_STATUS)
                    begin
                        status_next = b;
                    end
                end
                else if (is_receive)
                begin
                    if (pos_reg <= POS_ADDR_END)
                    begin
                        addr_next = {addr_reg[ADDR_W-BYTE_W-1:0], b};
                    end
                    else if (pos_reg >= POS_PAYLOAD)
                    begin
                        emit               = 1'b1;
                        item.result_kind   = KIND_PAYLOAD;
                        item.payload_byte  = b;
                        item.payload_index = pay_off[LEN_W-1:0];
                    end
                end
            end
        end
        else
        begin
            esc_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receive_code_reg <= RECEIVE_TYPE_RESET;
            status_code_reg  <= STATUS_TYPE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RECEIVE_TYPE: receive_code_reg <= cfg_data;
                REG_STATUS_TYPE:  status_code_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_HUNT;
            len_reg    <= '0;
            kind_reg   <= '0;
            sum_reg    <= '0;
            esc_reg    <= 1'b0;
            addr_reg   <= '0;
            status_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            kind_reg   <= kind_next;
            sum_reg    <= sum_next;
            esc_reg    <= esc_next;
            addr_reg   <= addr_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= emit;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_item_reg <= item;
        end
    end

    assign res_out.valid           = out_valid_reg;
    assign res_out.result_kind     = out_item_reg.result_kind;
    assign res_out.payload_byte    = out_item_reg.payload_byte;
    assign res_out.payload_index   = out_item_reg.payload_index;
    assign res_out.frame_kind_code = out_item_reg.frame_kind_code;
    assign res_out.sender_address  = out_item_reg.sender_address;
    assign res_out.delivery_status = out_item_reg.delivery_status;
    assign res_out.payload_length  = out_item_reg.payload_length;
    assign res_out.checksum_ok     = out_item_reg.checksum_ok;

    // an escape is only armed inside a frame
    a_esc_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> pos_reg != POS_HUNT)
        else $error("escape pending while hunting");

    // a report returns the parser to hunting with a cleared sum
    a_report_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit && item.result_kind == KIND_REPORT)
        |=> (pos_reg == POS_HUNT && sum_reg == '0))
        else $error("report did not restart hunting");

    // payload items only come from receive frames
    a_payload_receive: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit && item.result_kind == KIND_PAYLOAD)
        |-> (is_receive && !is_status && pos_reg >= POS_PAYLOAD))
        else $error("payload item outside a receive frame");

    // a held result blocks intake until it is taken
    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_out.ready) |-> !accept)
        else $error("item accepted over a stalled result");

endmodule

/* sim/api_frame_receiver_core_tb.sv */
// testbench of api_frame_receiver_core: escaped frames driven byte by byte, results checked
`timescale 1ns / 100ps

module api_frame_receiver_core_tb;
    import afr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_OFF       = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int MAX_SHOWN      = 10;
    localparam int RANDOM_BYTES   = 600;
    localparam int RANDOM_PHASES  = 4;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    afr_in_if  rx_if();
    afr_out_if res_if();

    api_frame_receiver_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_in     (rx_if),
        .res_out   (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // frame parser state
    logic [BYTE_W-1:0] cur_receive_code;
    logic [BYTE_W-1:0] cur_status_code;
    logic [POS_W-1:0]  parse_pos;
    logic [LEN_W-1:0]  frame_len;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] byte_sum;
    logic              escape_seen;
    logic [ADDR_W-1:0] last_address;
    logic [BYTE_W-1:0] last_status;

    afr_result_t pending_results[$];

    bit src_idle;
    bit snk_idle;
    int fail_count;
    int quiet_cycles;
    int bytes_sent;
    int frames_sent;
    int payloads_seen;
    int reports_seen;
    int settings_used;

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic string describe(input afr_result_t r);
        return {$sformatf("kind %0d byte %h index %0d type %h ",
                          r.result_kind, r.payload_byte, r.payload_index,
                          r.frame_kind_code),
                $sformatf("addr %h status %h length %0d sum_ok %0b",
                          r.sender_address, r.delivery_status, r.payload_length,
                          r.checksum_ok)};
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic reset_parser();
        cur_receive_code = RECEIVE_TYPE_RESET;
        cur_status_code  = STATUS_TYPE_RESET;
        parse_pos        = POS_HUNT;
        frame_len        = '0;
        frame_type       = '0;
        byte_sum         = '0;
        escape_seen      = 1'b0;
        last_address     = '0;
        last_status      = '0;
    endtask

    task automatic take_byte(input logic [BYTE_W-1:0] b);
        byte_sum  = byte_sum + b;
        parse_pos = parse_pos + 1'b1;
    endtask

    task automatic close_frame(input logic [BYTE_W-1:0] chk);
        afr_result_t r;
        logic [BYTE_W-1:0] want_sum;
        r = '0;
        want_sum = SUM_BASE - byte_sum;
        r.result_kind     = KIND_REPORT;
        r.frame_kind_code = frame_type;
        r.sender_address  = last_address;
        r.delivery_status = last_status;
        r.payload_length  = (frame_len >= HEADER_BYTES) ? frame_len - HEADER_BYTES : '0;
        r.checksum_ok     = (want_sum == chk);
        pending_results.push_back(r);
        parse_pos = POS_HUNT;
        byte_sum  = '0;
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] raw);
        logic [BYTE_W-1:0] b;
        logic [POS_W-1:0]  tail_pos;
        logic [POS_W-1:0]  index;
        afr_result_t       r;
        b = raw;
        tail_pos = {1'b0, frame_len} + POS_TAIL;
        r = '0;
        if (escape_seen)
        begin
            b = b ^ ESCAPE_FLIP;
            escape_seen = 1'b0;
        end
        else if (parse_pos != POS_HUNT && b == ESCAPE_MARK)
        begin
            escape_seen = 1'b1;
            return;
        end
        if (parse_pos == POS_HUNT)
        begin
            if (b == START_MARK)
            begin
                parse_pos = POS_LEN_HI;
                byte_sum  = '0;
            end
        end
        else if (parse_pos == POS_LEN_HI)
        begin
            frame_len = {8'h00, b};
            parse_pos = POS_LEN_LO;
        end
        else if (parse_pos == POS_LEN_LO)
        begin
            frame_len = {frame_len[7:0], b};
            parse_pos = POS_TYPE;
        end
        else if (parse_pos == POS_TYPE)
        begin
            frame_type = b;
            take_byte(b);
        end
        else if (frame_type == cur_status_code)
        begin
            if (parse_pos >= POS_STATUS_END)
                close_frame(b);
            else
            begin
                if (parse_pos == POS_STATUS)
                    last_status = b;
                take_byte(b);
            end
        end
        else if (frame_type == cur_receive_code)
        begin
            if (parse_pos <= POS_ADDR_END)
            begin
                last_address = {last_address[ADDR_W-9:0], b};
                take_byte(b);
            end
            else if (parse_pos < POS_PAYLOAD)
                take_byte(b);
            else if (parse_pos > tail_pos)
                close_frame(b);
            else
            begin
                index = parse_pos - POS_PAYLOAD;
                r.result_kind   = KIND_PAYLOAD;
                r.payload_byte  = b;
                r.payload_index = index[LEN_W-1:0];
                pending_results.push_back(r);
                take_byte(b);
            end
        end
        else if (parse_pos > tail_pos)
            close_frame(b);
        else
            take_byte(b);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = src_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_stuffed(input logic [BYTE_W-1:0] b);
        if (b == ESCAPE_MARK || (b == START_MARK && $urandom_range(0, 1) == 1)
            || $urandom_range(0, 7) == 0)
        begin
            send_byte(ESCAPE_MARK);
            send_byte(b ^ ESCAPE_FLIP);
        end
        else
            send_byte(b);
    endtask

    // cut < 0 sends the whole frame, else only that many bytes after the start byte
    task automatic send_frame(input logic [BYTE_W-1:0] kind, input logic [LEN_W-1:0] len,
                              input bit bad_sum, input int cut);
        logic [BYTE_W-1:0] body[$];
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] chk;
        int n;
        int stop;
        if (kind == cur_status_code)
            n = 6;
        else if (kind == cur_receive_code)
            n = (len >= 13) ? len - 1 : 11;
        else
            n = (len == 0) ? 0 : len - 1;
        body.push_back(len[15:8]);
        body.push_back(len[7:0]);
        body.push_back(kind);
        sum = kind;
        repeat (n)
        begin
            chk = BYTE_W'($urandom);
            body.push_back(chk);
            sum = sum + chk;
        end
        chk = SUM_BASE - sum;
        if (bad_sum)
            chk = chk ^ BYTE_W'($urandom_range(1, 255));
        body.push_back(chk);
        stop = (cut < 0 || cut >= body.size()) ? body.size() : cut;
        send_byte(START_MARK);
        for (int i = 0; i < stop; i++)
            send_stuffed(body[i]);
        // fill a cut frame with small bytes until the parser hunts again
        while (parse_pos != POS_HUNT)
            send_byte(BYTE_W'($urandom_range(0, 15)));
        frames_sent++;
    endtask

    task automatic settle();
        rx_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic set_type_codes(input logic [BYTE_W-1:0] rcv_code,
                                  input logic [BYTE_W-1:0] sts_code);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_RECEIVE_TYPE;
        cfg_data  <= rcv_code;
        @(posedge clk);
        cfg_index <= REG_STATUS_TYPE;
        cfg_data  <= sts_code;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_receive_code = rcv_code;
        cur_status_code  = sts_code;
        settings_used++;
    endtask

    task automatic test_hunting_and_stray_escape();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ESCAPE_MARK);
        send_frame(8'h00, 16'h0000, 1'b0, -1);
    endtask

    task automatic test_status_frame();
        send_frame(cur_status_code, 16'hFFFF, 1'b0, -1);
    endtask

    task automatic test_short_receive_frame();
        send_frame(cur_receive_code, 16'h0000, 1'b0, -1);
        send_frame(cur_receive_code, 16'd13, 1'b0, -1);
    endtask

    task automatic test_start_inside_frame();
        send_byte(START_MARK);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'h55);
        send_byte(START_MARK);
        send_byte(SUM_BASE - (8'h55 + START_MARK));
        frames_sent++;
    endtask

    task automatic test_bad_checksum();
        send_frame(8'h42, 16'd3, 1'b1, -1);
    endtask

    task automatic test_equal_type_codes();
        set_type_codes(8'h21, 8'h21);
        send_frame(8'h21, 16'd20, 1'b0, -1);
    endtask

    task automatic test_type_code_extremes();
        set_type_codes(8'h00, 8'hFF);
        send_frame(8'h00, 16'd14, 1'b0, -1);
        send_frame(8'hFF, 16'd0, 1'b1, -1);
        set_type_codes(8'hFF, 8'h00);
        send_frame(8'hFF, 16'd12, 1'b0, -1);
        send_frame(8'h00, 16'd1, 1'b0, -1);
        send_frame(8'h7E, 16'd2, 1'b0, -1);
    endtask

    task automatic test_full_rate_frame();
        set_type_codes(RECEIVE_TYPE_RESET, STATUS_TYPE_RESET);
        src_idle = 1'b0;
        snk_idle = 1'b0;
        send_frame(RECEIVE_TYPE_RESET, 16'd60, 1'b0, -1);
        settle();
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int pick;
        int noise_len;
        logic [BYTE_W-1:0] kind;
        logic [BYTE_W-1:0] noise;
        logic [LEN_W-1:0]  len;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_type_codes(RECEIVE_TYPE_RESET, STATUS_TYPE_RESET);
                1: set_type_codes(8'h00, 8'hFF);
                2: set_type_codes(8'hFF, 8'h00);
                default: set_type_codes(BYTE_W'($urandom), BYTE_W'($urandom));
            endcase
            stop_at = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
            while (bytes_sent < stop_at)
            begin
                src_idle = $urandom_range(0, 3) != 0;
                snk_idle = $urandom_range(0, 3) != 0;
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    noise_len = $urandom_range(1, 6);
                    stop_at = stop_at + noise_len;
                    repeat (noise_len)
                    begin
                        noise = BYTE_W'($urandom);
                        if (noise == START_MARK)
                            noise = ESCAPE_MARK;
                        send_byte(noise);
                    end
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: kind = cur_receive_code;
                        1: kind = cur_status_code;
                        default: kind = BYTE_W'($urandom);
                    endcase
                    len = LEN_W'(($urandom_range(0, 15) == 0) ? $urandom_range(41, 300)
                                                              : $urandom_range(0, 40));
                    send_frame(kind, len, $urandom_range(0, 7) == 0,
                               ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 40))
                                                           : -1);
                end
            end
        end
    endtask

    initial
    begin : result_sink
        int stall;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = snk_idle ? $urandom_range(0, 15) : 0;
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
        end
    end

    always @(posedge clk)
    begin : check_results
        afr_result_t seen;
        afr_result_t want;
        if (rst_n && res_if.valid === 1'b1 && res_if.ready)
        begin
            seen.result_kind     = result_kind_t'(res_if.result_kind);
            seen.payload_byte    = res_if.payload_byte;
            seen.payload_index   = res_if.payload_index;
            seen.frame_kind_code = res_if.frame_kind_code;
            seen.sender_address  = res_if.sender_address;
            seen.delivery_status = res_if.delivery_status;
            seen.payload_length  = res_if.payload_length;
            seen.checksum_ok     = res_if.checksum_ok;
            if (pending_results.size() == 0)
                report_failure({"unexpected item: ", describe(seen)});
            else
            begin
                want = pending_results.pop_front();
                if (want.result_kind == KIND_PAYLOAD)
                    payloads_seen++;
                else
                    reports_seen++;
                if (seen !== want)
                    report_failure({"mismatch: expected ", describe(want),
                                    " got ", describe(seen)});
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("api_frame_receiver_core_tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_RECEIVE_TYPE;
        cfg_data      <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        src_idle = 1'b1;
        snk_idle = 1'b1;
        reset_parser();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hunting_and_stray_escape();
        test_status_frame();
        test_short_receive_frame();
        test_start_inside_frame();
        test_bad_checksum();
        test_equal_type_codes();
        test_type_code_extremes();
        test_full_rate_frame();
        test_random_traffic();

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("sent %0d frames in %0d bytes over %0d type code settings",
                 frames_sent, bytes_sent, settings_used);
        $display("checked %0d payload items and %0d frame reports, %0d failures",
                 payloads_seen, reports_seen, fail_count);
        if (fail_count == 0)
            $display("api_frame_receiver_core_tb OK");
        else
            $display("api_frame_receiver_core_tb NOT OK");
        $finish;
    end

endmodule
